// ===== design/kwd_pkg.sv =====
// ----------------------------------------------------------------------------
// kwd_pkg
// Types and constants shared by the keyed watchdog files.
// ----------------------------------------------------------------------------
package kwd_pkg;

   localparam int unsigned MARK_WIDTH = 8;
   localparam logic [31:0] WD_KEY     = 32'h6E52_4635;
   localparam logic [31:0] CNT_RESET  = 32'hFFFF_FFFF;
   localparam logic [31:0] TMO_RESET  = 32'hFFFF_FFFF;
   localparam logic [MARK_WIDTH-1:0] MASK_RESET = 8'h01;

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_READ  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      TGT_START  = 2'd0,
      TGT_STOP   = 2'd1,
      TGT_KEY    = 2'd2,
      TGT_RELOAD = 2'd3
   } target_type;

   typedef enum logic [1:0] {
      REG_TIMEOUT     = 2'd0,
      REG_RELOAD_MASK = 2'd1,
      REG_RUN_SLEEP   = 2'd2,
      REG_STOP_ENABLE = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [31:0]           timeout_ticks;
      logic [MARK_WIDTH-1:0] reload_enable_mask;
      logic                  run_in_sleep;
      logic                  stop_enable;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  target;
      logic [2:0]  channel;
      logic [31:0] write_value;
      logic        asleep;
   } req_type;

   typedef struct packed {
      logic                  running;
      logic [31:0]           count_value;
      logic                  timeout_pulse;
      logic                  stop_armed;
      logic [MARK_WIDTH-1:0] pending_marks;
   } rsp_type;

endpackage

// ===== design/kwd_ifs.sv =====
// ----------------------------------------------------------------------------
// kwd channel interfaces
// Valid/ready channels for request items, result items and register writes.
// ----------------------------------------------------------------------------
interface kwd_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [1:0]  target;
   logic [2:0]  channel;
   logic [31:0] write_value;
   logic        asleep;

   modport source (output valid, kind, target, channel, write_value, asleep, input ready);
   modport sink   (input valid, kind, target, channel, write_value, asleep, output ready);
endinterface

interface kwd_rsp_if;
   logic        valid;
   logic        ready;
   logic        running;
   logic [31:0] count_value;
   logic        timeout_pulse;
   logic        stop_armed;
   logic [7:0]  pending_marks;

   modport source (output valid, running, count_value, timeout_pulse, stop_armed,
                   pending_marks, input ready);
   modport sink   (input valid, running, count_value, timeout_pulse, stop_armed,
                   pending_marks, output ready);
endinterface

interface kwd_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/kwd_csr.sv =====
// ----------------------------------------------------------------------------
// kwd_csr
// Configuration registers of the keyed watchdog.
// ----------------------------------------------------------------------------
module kwd_csr
   import kwd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        wr_valid,
   output logic        wr_ready,
   input  logic [1:0]  wr_index,
   input  logic [31:0] wr_data,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign wr_ready = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_valid) begin
         case (wr_index)
            REG_TIMEOUT:     cfg_in.timeout_ticks      = wr_data;
            REG_RELOAD_MASK: cfg_in.reload_enable_mask = wr_data[MARK_WIDTH-1:0];
            REG_RUN_SLEEP:   cfg_in.run_in_sleep       = wr_data[0];
            REG_STOP_ENABLE: cfg_in.stop_enable        = wr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ticks      <= TMO_RESET;
         cfg_ff.reload_enable_mask <= MASK_RESET;
         cfg_ff.run_in_sleep       <= 1'b0;
         cfg_ff.stop_enable        <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== design/kwd_core.sv =====
// ----------------------------------------------------------------------------
// kwd_core
// Input register, watchdog state update and result register.
// ----------------------------------------------------------------------------
module kwd_core
   import kwd_pkg::*;
#(
   parameter int unsigned RELOAD_CHANNELS = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_item,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_item
);

   localparam logic [MARK_WIDTH-1:0] SPAN =
      MARK_WIDTH'((64'd1 << RELOAD_CHANNELS) - 64'd1);
   localparam logic [3:0] CHAN_LIMIT = 4'(RELOAD_CHANNELS);

   logic                  in_valid_ff, in_valid_in;
   req_type               in_item_ff;
   logic                  out_valid_ff, out_valid_in;
   rsp_type               out_item_ff, out_item_in;

   logic [31:0]           counter_ff, counter_in;
   logic                  running_ff, running_in;
   logic                  armed_ff, armed_in;
   logic [MARK_WIDTH-1:0] marks_ff, marks_in;

   logic                  advance;
   logic                  key_ok;
   logic                  chan_ok;
   logic                  pulse;
   logic [MARK_WIDTH-1:0] enabled;
   logic [MARK_WIDTH-1:0] marks_new;

   assign advance   = in_valid_ff && (!out_valid_ff || out_ready);
   assign in_ready  = !in_valid_ff || advance;
   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;

   assign key_ok    = (in_item_ff.write_value == WD_KEY);
   assign chan_ok   = ({1'b0, in_item_ff.channel} < CHAN_LIMIT);
   assign enabled   = cfg.reload_enable_mask & SPAN;
   assign marks_new = marks_ff | ((MARK_WIDTH'(1) << in_item_ff.channel) & enabled);

   always_comb begin
      counter_in = counter_ff;
      running_in = running_ff;
      armed_in   = armed_ff;
      marks_in   = marks_ff;
      pulse      = 1'b0;
      case (in_item_ff.kind)
         KIND_TICK: begin
            if (running_ff && (!in_item_ff.asleep || cfg.run_in_sleep)) begin
               if (counter_ff <= 32'd1) begin
                  pulse      = 1'b1;
                  running_in = 1'b0;
                  counter_in = cfg.timeout_ticks;
                  marks_in   = '0;
               end else begin
                  counter_in = counter_ff - 32'd1;
               end
            end
         end
         KIND_WRITE: begin
            armed_in = 1'b0;
            case (in_item_ff.target)
               TGT_START: begin
                  if (!running_ff) begin
                     counter_in = cfg.timeout_ticks;
                     marks_in   = '0;
                     running_in = 1'b1;
                  end
               end
               TGT_STOP: begin
                  if (cfg.stop_enable && armed_ff) begin
                     running_in = 1'b0;
                  end
               end
               TGT_KEY: armed_in = key_ok;
               TGT_RELOAD: begin
                  if (key_ok && chan_ok) begin
                     if ((enabled != '0) && ((marks_new & enabled) == enabled)) begin
                        counter_in = cfg.timeout_ticks;
                        marks_in   = '0;
                     end else begin
                        marks_in = marks_new;
                     end
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   always_comb begin
      out_item_in.running       = running_in;
      out_item_in.count_value   = counter_in;
      out_item_in.timeout_pulse = pulse;
      out_item_in.stop_armed    = armed_in;
      out_item_in.pending_marks = marks_in;
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (in_valid && in_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         counter_ff   <= CNT_RESET;
         running_ff   <= 1'b0;
         armed_ff     <= 1'b0;
         marks_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            counter_ff <= counter_in;
            running_ff <= running_in;
            armed_ff   <= armed_in;
            marks_ff   <= marks_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         in_item_ff <= in_item;
      end
      if (advance) begin
         out_item_ff <= out_item_in;
      end
   end

   a_pulse_stops: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_item_ff.timeout_pulse |->
         !out_item_ff.running && (out_item_ff.pending_marks == '0))
      else $error("timeout pulse without stop");

   a_pulse_reload: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_item_ff.timeout_pulse |->
         out_item_ff.count_value == cfg.timeout_ticks)
      else $error("timeout pulse without reload");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> in_ready)
      else $error("input stalled with empty result register");

   a_result_tracks_state: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_item_ff.count_value == counter_ff &&
                  out_item_ff.running == running_ff)
      else $error("result out of step with state");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !in_valid_ff && !out_valid_ff)
      else $error("pipeline not empty after reset");

endmodule

// ===== design/keyed_watchdog_with_gated_stop.sv =====
// ----------------------------------------------------------------------------
// keyed_watchdog_with_gated_stop
// Watchdog down-counter with keyed reload channels and a gated stop task.
// ----------------------------------------------------------------------------
// an accepted item passes the input register, then the result register
// throughput: one item per cycle while the result register is not stalled, set by the state update
// a stalled result register holds one item while one more waits at the input
// reset: synchronous, clears counter to all ones, stopped, key disarmed, no marks
// reset loads timeout all ones, reload mask 1, run_in_sleep and stop_enable 0
module keyed_watchdog_with_gated_stop
   import kwd_pkg::*;
#(
   parameter int unsigned RELOAD_CHANNELS = 8
) (
   input  logic clock,
   input  logic reset,
   kwd_req_if.sink   req_bus,
   kwd_rsp_if.source rsp_bus,
   kwd_csr_if.sink   csr_bus
);

   cfg_type cfg;
   req_type req_item;
   rsp_type rsp_item;

   assign req_item.kind        = req_bus.kind;
   assign req_item.target      = req_bus.target;
   assign req_item.channel     = req_bus.channel;
   assign req_item.write_value = req_bus.write_value;
   assign req_item.asleep      = req_bus.asleep;

   assign rsp_bus.running       = rsp_item.running;
   assign rsp_bus.count_value   = rsp_item.count_value;
   assign rsp_bus.timeout_pulse = rsp_item.timeout_pulse;
   assign rsp_bus.stop_armed    = rsp_item.stop_armed;
   assign rsp_bus.pending_marks = rsp_item.pending_marks;

   kwd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_bus.valid),
      .wr_ready (csr_bus.ready),
      .wr_index (csr_bus.index),
      .wr_data  (csr_bus.data),
      .cfg      (cfg)
   );

   kwd_core #(
      .RELOAD_CHANNELS (RELOAD_CHANNELS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_item   (req_item),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_item  (rsp_item)
   );

endmodule
